// File: hw/rtl/htce_pkg.sv
// Package for the HTML table cell extractor: shared constants and the types
// that pass between the parser, the command queue and the emitter.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package htce_pkg;

   // Defaults for the top-level parameters.
   localparam int TEXT_DEPTH_DEF  = 64;
   localparam int COUNT_WIDTH_DEF = 16;

   // Width of a text length; covers every store depth up to 127 bytes.
   localparam int LEN_W = 7;

   // Widths of the fixed payload fields.
   localparam int BYTE_W = 8;
   localparam int NUM_W  = 16;

   // Result kinds.
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] REG_ROW_FIRST = 2'd0;
   localparam logic [1:0] REG_ROW_LAST  = 2'd1;
   localparam logic [1:0] REG_COL_FIRST = 2'd2;
   localparam logic [1:0] REG_COL_LAST  = 2'd3;

   // Character codes used by the parser.
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   // One command from the parser to the emitter: a cell or a row marker.
   typedef struct packed {
      logic             kind;
      logic [NUM_W-1:0] row;
      logic [NUM_W-1:0] col;
      logic [LEN_W-1:0] len;
      logic             trunc;
   } cmd_type;

   // Write into the cell text store.
   typedef struct packed {
      logic              en;
      logic [LEN_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   function automatic logic is_ws(input logic [7:0] c);
      is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      to_upper = ((c >= CH_LC_A) && (c <= CH_LC_Z)) ? (c - CASE_OFS) : c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/htce_if.sv
// Handshake channels of the HTML table cell extractor: the byte input and
// the result output. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface htce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface htce_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] row_num;
   logic [15:0] col_num;
   logic [7:0]  text_byte;
   logic        last_of_cell;
   logic        truncated;

   modport source (output valid, output kind, output row_num, output col_num,
                   output text_byte, output last_of_cell, output truncated,
                   input ready);
   modport sink   (input valid, input kind, input row_num, input col_num,
                   input text_byte, input last_of_cell, input truncated,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/htce_front.sv
// Parser front end: accepts stream bytes, tracks the tag phase, the row and
// column counters and the window registers, writes the text store and issues
// cell and row commands. Depends on htce_pkg and htce_if.
`timescale 1ns / 1ps
`default_nettype none

module htce_front
   import htce_pkg::*;
#(
   parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   htce_req_if.sink          req,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   output store_wr_type      store_wr,
   output cmd_type           cmd,
   output logic              cmd_valid,
   input  wire logic         cmd_ready,
   input  wire logic         cell_done
);

   localparam int CMP_W = (COUNT_WIDTH > NUM_W) ? COUNT_WIDTH : NUM_W;

   localparam logic [2:0] PH_TEXT        = 3'd0;
   localparam logic [2:0] PH_AFTER_LT    = 3'd1;
   localparam logic [2:0] PH_AFTER_SLASH = 3'd2;
   localparam logic [2:0] PH_AFTER_T     = 3'd3;
   localparam logic [2:0] PH_SKIP        = 3'd4;
   localparam logic [2:0] PH_SKIP_CELL   = 3'd5;
   localparam logic [2:0] PH_SKIP_ROW    = 3'd6;

   logic [2:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] row_ff, row_in;
   logic [COUNT_WIDTH-1:0] col_ff, col_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic                   busy_ff, busy_in;
   logic [15:0]            row_first_ff, row_last_ff, col_first_ff, col_last_ff;

   logic             accept;
   logic [7:0]       c;
   logic [7:0]       cu;
   logic [CMP_W-1:0] row_ext, col_ext, row_inc_ext;
   logic             in_window;
   logic [COUNT_WIDTH-1:0] row_inc;

   // New bytes wait during reset, while the command queue is full and while a cell is being read out of the store.
   assign req.ready = cmd_ready && !busy_ff && !reset;
   assign accept    = req.valid && req.ready;
   assign c         = req.in_byte;
   assign cu        = to_upper(c);

   assign row_ext   = CMP_W'(row_ff);
   assign col_ext   = CMP_W'(col_ff);
   assign in_window = (CMP_W'(row_first_ff) <= row_ext) && (row_ext <= CMP_W'(row_last_ff)) &&
                      (CMP_W'(col_first_ff) <= col_ext) && (col_ext <= CMP_W'(col_last_ff));
   assign row_inc     = (row_ff != {COUNT_WIDTH{1'b1}}) ? (row_ff + 1'b1) : row_ff;
   assign row_inc_ext = CMP_W'(row_inc);

   // Phase and counter update for one accepted byte.
   always_comb begin
      phase_in  = phase_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      busy_in   = busy_ff && !cell_done;
      store_wr  = '0;
      cmd       = '0;
      cmd_valid = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_TEXT: begin
               if (c == CH_LT) begin
                  phase_in = PH_AFTER_LT;
               end else if (c == CH_GT) begin
                  len_in = '0;
                  ovf_in = 1'b0;
               end else if (len_ff < LEN_W'(TEXT_DEPTH)) begin
                  store_wr.en   = 1'b1;
                  store_wr.addr = len_ff;
                  store_wr.data = c;
                  len_in        = len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            PH_AFTER_LT: begin
               if (!is_ws(c)) begin
                  if (c == CH_SLASH) begin
                     phase_in = PH_AFTER_SLASH;
                  end else if (c == CH_GT) begin
                     len_in   = '0;
                     ovf_in   = 1'b0;
                     phase_in = PH_TEXT;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_AFTER_SLASH: begin
               if (!is_ws(c)) begin
                  phase_in = (cu == CH_T) ? PH_AFTER_T : PH_TEXT;
               end
            end
            PH_AFTER_T: begin
               if (!is_ws(c)) begin
                  if (cu == CH_D) begin
                     phase_in = PH_SKIP_CELL;
                  end else if (cu == CH_R) begin
                     phase_in = PH_SKIP_ROW;
                  end else if (c == CH_GT) begin
                     len_in   = '0;
                     ovf_in   = 1'b0;
                     phase_in = PH_TEXT;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP_CELL: begin
               if (c == CH_GT) begin
                  if ((len_ff != '0) && in_window) begin
                     cmd.kind  = KIND_TEXT;
                     cmd.row   = row_ext[NUM_W-1:0];
                     cmd.col   = col_ext[NUM_W-1:0];
                     cmd.len   = len_ff;
                     cmd.trunc = ovf_ff;
                     cmd_valid = 1'b1;
                     busy_in   = 1'b1;
                  end
                  if (col_ff != {COUNT_WIDTH{1'b1}}) begin
                     col_in = col_ff + 1'b1;
                  end
                  len_in   = '0;
                  ovf_in   = 1'b0;
                  phase_in = PH_TEXT;
               end
            end
            PH_SKIP_ROW: begin
               if (c == CH_GT) begin
                  row_in    = row_inc;
                  col_in    = COUNT_WIDTH'(1);
                  cmd.kind  = KIND_ROW;
                  cmd.row   = row_inc_ext[NUM_W-1:0];
                  cmd.col   = NUM_W'(1);
                  cmd.len   = '0;
                  cmd.trunc = 1'b0;
                  cmd_valid = 1'b1;
                  len_in    = '0;
                  ovf_in    = 1'b0;
                  phase_in  = PH_TEXT;
               end
            end
            default: begin
               if (c == CH_GT) begin
                  len_in   = '0;
                  ovf_in   = 1'b0;
                  phase_in = PH_TEXT;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         endcase
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         row_ff   <= COUNT_WIDTH'(1);
         col_ff   <= COUNT_WIDTH'(1);
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         busy_ff  <= busy_in;
      end
   end

   // Window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_first_ff <= 16'h0000;
         row_last_ff  <= 16'hFFFF;
         col_first_ff <= 16'h0000;
         col_last_ff  <= 16'hFFFF;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROW_FIRST: row_first_ff <= csr_wdata;
            REG_ROW_LAST:  row_last_ff  <= csr_wdata;
            REG_COL_FIRST: col_first_ff <= csr_wdata;
            REG_COL_LAST:  col_last_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/htce_queue.sv
// Two-entry command queue between the parser and the emitter.
// Depends on htce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htce_queue
   import htce_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  cmd_type       in_cmd,
   input  wire logic     in_valid,
   output logic          in_ready,
   output cmd_type       out_cmd,
   output logic          out_valid,
   input  wire logic     out_ready
);

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/htce_back.sv
// Emitter back end: holds the cell text store, takes commands from the queue
// and sends row markers and cell bytes through a result register.
// Depends on htce_pkg and htce_if.
`timescale 1ns / 1ps
`default_nettype none

module htce_back
   import htce_pkg::*;
#(
   parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  store_wr_type  store_wr,
   input  cmd_type       cmd,
   input  wire logic     cmd_valid,
   output logic          cmd_ready,
   output logic          cell_done,
   htce_rsp_if.source    rsp
);

   localparam int ADDR_W = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [BYTE_W-1:0] mem [TEXT_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [1:0]        state_ff, state_in;
   cmd_type           cur_ff, cur_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [NUM_W-1:0]  out_row_ff, out_row_in;
   logic [NUM_W-1:0]  out_col_ff, out_col_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_trunc_ff, out_trunc_in;

   logic              out_free;
   logic              last_byte;

   // Text store: written by the parser, read by the sequencer.
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         mem[store_wr.addr[ADDR_W-1:0]] <= store_wr.data;
      end
      rd_data_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   assign out_free  = !out_valid_ff || rsp.ready;
   assign last_byte = (idx_ff == (cur_ff.len - 1'b1));

   // Sequencer: one store read, then one result load, per cell byte.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      cmd_ready    = 1'b0;
      cell_done    = 1'b0;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_kind_in  = out_kind_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_trunc_in = out_trunc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == KIND_ROW) begin
                  if (out_free) begin
                     cmd_ready    = 1'b1;
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_ROW;
                     out_row_in   = cmd.row;
                     out_col_in   = cmd.col;
                     out_byte_in  = '0;
                     out_last_in  = 1'b1;
                     out_trunc_in = 1'b0;
                  end
               end else begin
                  cmd_ready = 1'b1;
                  cur_in    = cmd;
                  idx_in    = '0;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_TEXT;
               out_row_in   = cur_ff.row;
               out_col_in   = cur_ff.col;
               out_byte_in  = rd_data_ff;
               out_last_in  = last_byte;
               out_trunc_in = cur_ff.trunc;
               if (last_byte) begin
                  cell_done = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      out_kind_ff  <= out_kind_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_kind_ff;
   assign rsp.row_num      = out_row_ff;
   assign rsp.col_num      = out_col_ff;
   assign rsp.text_byte    = out_byte_ff;
   assign rsp.last_of_cell = out_last_ff;
   assign rsp.truncated    = out_trunc_ff;

endmodule

`default_nettype wire

// File: hw/rtl/html_table_cell_extractor_core.sv
// HTML table cell extractor. Plain text, tag and row bytes are taken at one
// item per cycle while the command queue has room. When a cell closes, input
// waits while the text is read out of the store: each cell byte takes a store
// read and then a result load in the back-end sequencer. A result is held in
// its register until taken. Reset is synchronous: phase to plain text, row
// and column to one, window to its full range; the text store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module html_table_cell_extractor_core
   import htce_pkg::*;
#(
   parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   htce_req_if.sink         req_ch,
   htce_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   store_wr_type store_wr;
   cmd_type      push_cmd, pop_cmd;
   logic         push_valid, push_ready;
   logic         pop_valid, pop_ready;
   logic         cell_done;

   // Parser.
   htce_front #(
      .TEXT_DEPTH  (TEXT_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .store_wr  (store_wr),
      .cmd       (push_cmd),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cell_done (cell_done)
   );

   // Command queue.
   htce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (push_cmd),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .out_cmd   (pop_cmd),
      .out_valid (pop_valid),
      .out_ready (pop_ready)
   );

   // Emitter.
   htce_back #(
      .TEXT_DEPTH (TEXT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .store_wr  (store_wr),
      .cmd       (pop_cmd),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cell_done (cell_done),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire
